### src/utf8sd_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies; every other file but the checker refers to it by scoped names.
package utf8sd_pkg;

   localparam int BYTE_W = 8;
   localparam int CODE_W = 31;
   localparam int CNT_W  = 3;

   localparam logic [BYTE_W-1:0] LEAD_MIN = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD_END = 8'hFE;
   localparam logic [1:0]        CONT_TAG = 2'b10;
   localparam logic [CODE_W-1:0] ASCII_MAX = 31'h7F;

   // result produced after any flush of the open sequence
   localparam logic [2:0] TAIL_NONE   = 3'd0;
   localparam logic [2:0] TAIL_CODE   = 3'd1;
   localparam logic [2:0] TAIL_RAW    = 3'd2;
   localparam logic [2:0] TAIL_RAW_FB = 3'd3;
   localparam logic [2:0] TAIL_EOS    = 3'd4;

   // sequence state update when an item retires
   localparam logic [1:0] SEQ_APPEND = 2'd0;
   localparam logic [1:0] SEQ_CLOSE  = 2'd1;
   localparam logic [1:0] SEQ_OPEN   = 2'd2;

   typedef struct packed {
      logic [BYTE_W-1:0] lead;
      logic [CNT_W-1:0]  expected;
      logic [CNT_W-1:0]  received;
   } seq_type;

   typedef struct packed {
      logic [CNT_W-1:0] flush_n;
      logic [2:0]       tail_kind;
      logic [CNT_W-1:0] total_n;
      logic [1:0]       seq_op;
      logic [CNT_W-1:0] new_len;
   } plan_type;

   typedef struct packed {
      logic [CODE_W-1:0] code_point;
      logic              fallback;
      logic              end_of_string;
   } result_type;

endpackage

### src/utf8sd_seq.sv
// Open-sequence state: lead byte, expected length, buffered continuations.
// Depends on utf8sd_pkg.
module utf8sd_seq #(
   parameter int MAX_SEQUENCE_BYTES = 6
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      upd_i,
   input  logic [1:0]                                op_i,
   input  logic [utf8sd_pkg::BYTE_W-1:0]             byte_i,
   input  logic [utf8sd_pkg::CNT_W-1:0]              len_i,
   output utf8sd_pkg::seq_type                       seq_o,
   output logic [MAX_SEQUENCE_BYTES-2:0][utf8sd_pkg::BYTE_W-1:0] cont_o
);

   localparam int DEPTH = MAX_SEQUENCE_BYTES - 1;

   utf8sd_pkg::seq_type seq_ff, seq_in;
   logic [DEPTH-1:0][utf8sd_pkg::BYTE_W-1:0] cont_ff, cont_in;

   always_comb begin
      seq_in  = seq_ff;
      cont_in = cont_ff;
      if (upd_i) begin
         case (op_i)
            utf8sd_pkg::SEQ_APPEND: begin
               seq_in.received = seq_ff.received + utf8sd_pkg::CNT_W'(1);
               for (int i = 0; i < DEPTH; i++) begin
                  if (seq_ff.received == utf8sd_pkg::CNT_W'(i)) begin
                     cont_in[i] = byte_i;
                  end
               end
            end
            utf8sd_pkg::SEQ_OPEN: begin
               seq_in.lead     = byte_i;
               seq_in.expected = len_i;
               seq_in.received = '0;
            end
            default: begin
               seq_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= '0;
      end else begin
         seq_ff <= seq_in;
      end
   end

   always_ff @(posedge clock) begin
      cont_ff <= cont_in;
   end

   assign seq_o  = seq_ff;
   assign cont_o = cont_ff;

endmodule

### src/utf8sd_decode.sv
// Per-byte plan (flush count, trailing result, state update) and result select.
// Depends on utf8sd_pkg.
module utf8sd_decode #(
   parameter int MAX_SEQUENCE_BYTES = 6
) (
   input  logic [utf8sd_pkg::BYTE_W-1:0]                         byte_i,
   input  utf8sd_pkg::seq_type                                   seq_i,
   input  logic [MAX_SEQUENCE_BYTES-2:0][utf8sd_pkg::BYTE_W-1:0] cont_i,
   input  logic [utf8sd_pkg::CNT_W-1:0]                          idx_i,
   output utf8sd_pkg::plan_type                                  plan_o,
   output utf8sd_pkg::result_type                                res_o
);

   localparam int DEPTH = MAX_SEQUENCE_BYTES - 1;
   localparam int CW    = utf8sd_pkg::CNT_W;

   logic [DEPTH-1:0][utf8sd_pkg::BYTE_W-1:0] cx;
   logic                                     seq_open, is_cont, complete, k_small;
   logic [31:0]                              k_wide;
   logic [utf8sd_pkg::CODE_W-1:0]            k;
   logic [2:0]                               start_kind;
   logic [1:0]                               start_op;
   logic [CW-1:0]                            start_len;

   // continuations with the current byte in the next free slot
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cx[i] = (seq_i.received == CW'(i)) ? byte_i : cont_i[i];
      end
   end

   assign seq_open = (seq_i.expected != '0);
   assign is_cont  = (byte_i[7:6] == utf8sd_pkg::CONT_TAG);
   assign complete = ((CW+1)'(seq_i.received) + (CW+1)'(2)) == (CW+1)'(seq_i.expected);

   always_comb begin
      k_wide = '0;
      for (int n = 2; n <= MAX_SEQUENCE_BYTES; n++) begin
         if (seq_i.expected == CW'(n)) begin
            k_wide = 32'(seq_i.lead & 8'(8'hFF >> (n + 1))) << (6 * (n - 1));
            for (int i = 0; i < n - 1; i++) begin
               k_wide = k_wide | (32'(cx[i][5:0]) << (6 * (n - 2 - i)));
            end
         end
      end
   end

   assign k       = k_wide[utf8sd_pkg::CODE_W-1:0];
   assign k_small = (k <= utf8sd_pkg::ASCII_MAX);

   always_comb begin
      start_len = '0;
      if (byte_i == '0) begin
         start_kind = utf8sd_pkg::TAIL_EOS;
         start_op   = utf8sd_pkg::SEQ_CLOSE;
      end else if (byte_i >= utf8sd_pkg::LEAD_MIN && byte_i < utf8sd_pkg::LEAD_END) begin
         unique case (byte_i[5:2]) inside
            4'b0???: start_len = CW'(2);
            4'b10??: start_len = CW'(3);
            4'b110?: start_len = CW'(4);
            4'b1110: start_len = CW'(5);
            default: start_len = CW'(6);
         endcase
         if (start_len > CW'(MAX_SEQUENCE_BYTES)) begin
            start_kind = utf8sd_pkg::TAIL_RAW_FB;
            start_op   = utf8sd_pkg::SEQ_CLOSE;
         end else begin
            start_kind = utf8sd_pkg::TAIL_NONE;
            start_op   = utf8sd_pkg::SEQ_OPEN;
         end
      end else if (byte_i >= utf8sd_pkg::LEAD_END) begin
         start_kind = utf8sd_pkg::TAIL_RAW_FB;
         start_op   = utf8sd_pkg::SEQ_CLOSE;
      end else begin
         start_kind = utf8sd_pkg::TAIL_RAW;
         start_op   = utf8sd_pkg::SEQ_CLOSE;
      end
   end

   always_comb begin
      plan_o.flush_n   = '0;
      plan_o.tail_kind = start_kind;
      plan_o.seq_op    = start_op;
      plan_o.new_len   = start_len;
      if (seq_open) begin
         if (is_cont && seq_i.received < CW'(DEPTH)) begin
            plan_o.tail_kind = utf8sd_pkg::TAIL_NONE;
            if (complete) begin
               plan_o.seq_op = utf8sd_pkg::SEQ_CLOSE;
               if (k_small) begin
                  plan_o.flush_n = seq_i.received + CW'(2);
               end else begin
                  plan_o.tail_kind = utf8sd_pkg::TAIL_CODE;
               end
            end else begin
               plan_o.seq_op = utf8sd_pkg::SEQ_APPEND;
            end
         end else begin
            // broken sequence: lead and buffered bytes go out raw first
            plan_o.flush_n = seq_i.received + CW'(1);
         end
      end
      plan_o.total_n = plan_o.flush_n
                     + CW'(plan_o.tail_kind != utf8sd_pkg::TAIL_NONE);
   end

   always_comb begin
      res_o = '0;
      if (idx_i < plan_o.flush_n) begin
         if (idx_i == '0) begin
            res_o.code_point = utf8sd_pkg::CODE_W'(seq_i.lead);
            res_o.fallback   = 1'b1;
         end else begin
            for (int i = 0; i < DEPTH; i++) begin
               if (idx_i == CW'(i + 1)) begin
                  res_o.code_point = utf8sd_pkg::CODE_W'(cx[i]);
               end
            end
         end
      end else begin
         case (plan_o.tail_kind)
            utf8sd_pkg::TAIL_CODE: res_o.code_point = k;
            utf8sd_pkg::TAIL_RAW:  res_o.code_point = utf8sd_pkg::CODE_W'(byte_i);
            utf8sd_pkg::TAIL_RAW_FB: begin
               res_o.code_point = utf8sd_pkg::CODE_W'(byte_i);
               res_o.fallback   = 1'b1;
            end
            utf8sd_pkg::TAIL_EOS:  res_o.end_of_string = 1'b1;
            default:               res_o = '0;
         endcase
      end
   end

endmodule

### src/utf8_stream_decoder.sv
// UTF-8 stream decoder top level: input register, result sequencing, output register.
// Depends on utf8sd_pkg, utf8sd_seq, utf8sd_decode.
//
// Usage:
//   req_* carries one byte per item (req_tdata[7:0]); a zero byte ends a string.
//   rsp_* carries one result per item: code point or raw byte, string_invalid,
//   and in rsp_tuser the fallback and end_of_string flags; rsp_tlast marks the
//   last result caused by one input byte.
//   A byte is held in the input register and its results go out one per cycle,
//   while rsp_tready stays high, through the output register: the first result
//   is registered there after the byte, and that register drives rsp_tvalid.
//   Throughput: one byte per cycle while each byte yields at most one result and
//   rsp_tready stays high. A byte yielding more than one result (a flushed sequence,
//   up to six) holds the input register until its last result is emitted. Bytes
//   that only open or extend a sequence retire with no result.
//   When rsp_tready is low the output register holds its result, the input
//   register holds its byte, and req_tready drops once the held byte has a
//   result waiting to go out.
//   Reset closes any open sequence, clears the invalid flag and empties both
//   registers.
module utf8_stream_decoder #(
   parameter int MAX_SEQUENCE_BYTES = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [30:0] code_point, [31] string_invalid
   output logic [1:0]  rsp_tuser,   // [0] fallback, [1] end_of_string
   output logic        rsp_tlast
);

   localparam int CW = utf8sd_pkg::CNT_W;

   logic                            in_valid_ff, in_valid_in;
   logic [utf8sd_pkg::BYTE_W-1:0]   in_byte_ff, in_byte_in;
   logic [CW-1:0]                   idx_ff, idx_in;
   logic                            invalid_ff, invalid_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   utf8sd_pkg::result_type          rsp_res_ff, rsp_res_in;
   logic                            rsp_inv_ff, rsp_inv_in;
   logic                            rsp_last_ff, rsp_last_in;

   utf8sd_pkg::seq_type             seq;
   logic [MAX_SEQUENCE_BYTES-2:0][utf8sd_pkg::BYTE_W-1:0] cont;
   utf8sd_pkg::plan_type            plan;
   utf8sd_pkg::result_type          res;
   logic                            emit, last_res, done, accept;

   utf8sd_seq #(.MAX_SEQUENCE_BYTES(MAX_SEQUENCE_BYTES)) u_seq (
      .clock  (clock),
      .reset  (reset),
      .upd_i  (done),
      .op_i   (plan.seq_op),
      .byte_i (in_byte_ff),
      .len_i  (plan.new_len),
      .seq_o  (seq),
      .cont_o (cont)
   );

   utf8sd_decode #(.MAX_SEQUENCE_BYTES(MAX_SEQUENCE_BYTES)) u_decode (
      .byte_i (in_byte_ff),
      .seq_i  (seq),
      .cont_i (cont),
      .idx_i  (idx_ff),
      .plan_o (plan),
      .res_o  (res)
   );

   assign emit     = in_valid_ff && (plan.total_n != '0) && (!rsp_valid_ff || rsp_tready);
   assign last_res = (idx_ff == plan.total_n - CW'(1));
   assign done     = in_valid_ff && ((plan.total_n == '0) || (emit && last_res));
   assign req_tready = !in_valid_ff || done;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (accept) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
      end else if (done) begin
         in_valid_in = 1'b0;
      end

      idx_in = idx_ff;
      if (done) begin
         idx_in = '0;
      end else if (emit) begin
         idx_in = idx_ff + CW'(1);
      end

      invalid_in   = invalid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_res_in   = rsp_res_ff;
      rsp_inv_in   = rsp_inv_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = res;
         rsp_inv_in   = invalid_ff || res.fallback;
         rsp_last_in  = last_res;
         // end of string reports the flag, then clears it
         invalid_in   = res.end_of_string ? 1'b0 : (invalid_ff || res.fallback);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         idx_ff       <= '0;
         invalid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         idx_ff       <= idx_in;
         invalid_ff   <= invalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      rsp_res_ff  <= rsp_res_in;
      rsp_inv_ff  <= rsp_inv_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_inv_ff, rsp_res_ff.code_point};
   assign rsp_tuser  = {rsp_res_ff.end_of_string, rsp_res_ff.fallback};
   assign rsp_tlast  = rsp_last_ff;

endmodule

### src/utf8sd_checker.sv
// Port-level checks for utf8_stream_decoder, attached with bind.
// Depends on utf8_stream_decoder ports only.
module utf8sd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_eos_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata[30:0] == 31'd0 && rsp_tlast && !rsp_tuser[0])
      else $error("end of string item malformed");

   a_fb_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[31] && rsp_tdata[30:8] == 23'd0)
      else $error("fallback item malformed");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("result valid right after reset");

   a_ready_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> req_tready)
      else $error("input not ready right after reset");

endmodule

bind utf8_stream_decoder utf8sd_checker u_utf8sd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
